// ===== hw/rtl/swmf_pkg.sv =====
package swmf_pkg;

  localparam int MAX_SIZE   = 1024;
  localparam int MAX_RADIUS = 3;
  localparam int PIXEL_BITS = 16;

  localparam int SIZE_W   = 11;                      // image_size register
  localparam int RAD_W    = 2;                       // window_radius register
  localparam int COL_W    = $clog2(MAX_SIZE);        // row / column counters
  localparam int SLOTS    = 2 * MAX_RADIUS + 2;      // line store rows
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int WIN_SIDE = 2 * MAX_RADIUS + 1;
  localparam int WIN_N    = WIN_SIDE * WIN_SIDE;
  localparam int RANK_W   = $clog2(WIN_N + 1);
  localparam int LAG_W    = $clog2(MAX_RADIUS * MAX_SIZE + MAX_RADIUS + 2);
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic REG_IMAGE_SIZE    = 1'b0;
  localparam logic REG_WINDOW_RADIUS = 1'b1;

  typedef logic [PIXEL_BITS-1:0] pixel_t;
  typedef pixel_t [WIN_SIDE-1:0] column_t;   // index 0 = newest row
  typedef column_t [WIN_SIDE-1:0] window_t;  // index 0 = newest column

  typedef struct packed {
    logic              border;
    logic [COL_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              frame_end;
  } meta_t;

  typedef struct packed {
    pixel_t            pixel;
    logic [COL_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              frame_end;
  } out_word_t;

endpackage

// ===== hw/rtl/swmf_ram.sv =====
module swmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== hw/rtl/swmf_cell.sv =====
// One window column; takes its neighbour's column on each shift.
module swmf_cell (
  input  logic              clk,
  input  logic              shift,
  input  swmf_pkg::column_t col_in,
  output swmf_pkg::column_t col_out
);

  swmf_pkg::column_t col_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      col_r <= col_in;
    end
  end

  assign col_out = col_r;

endmodule

// ===== hw/rtl/swmf_rank.sv =====
// Median by rank: compare all pairs, count, pick the element of middle rank.
// Two register stages (compare, select); median is formed combinationally.
module swmf_rank (
  input  logic                        clk,
  input  swmf_pkg::window_t           win,
  input  logic [swmf_pkg::RAD_W-1:0]  radius,
  output swmf_pkg::pixel_t            median
);

  logic [swmf_pkg::WIN_N-1:0]  lt     [swmf_pkg::WIN_N];
  logic [swmf_pkg::WIN_N-1:0]  lt_r   [swmf_pkg::WIN_N];
  swmf_pkg::pixel_t            vals   [swmf_pkg::WIN_N];
  swmf_pkg::pixel_t            vals_r [swmf_pkg::WIN_N];
  swmf_pkg::pixel_t            vals2_r[swmf_pkg::WIN_N];
  logic [swmf_pkg::WIN_N-1:0]  act, act_r, hit, sel_r;
  logic [swmf_pkg::RANK_W-1:0] tgt, tgt_r;
  logic [swmf_pkg::RAD_W:0]    span;

  always_comb begin
    span = {radius, 1'b0};
    for (int e = 0; e < swmf_pkg::WIN_N; e++) begin
      vals[e] = win[e / swmf_pkg::WIN_SIDE][e % swmf_pkg::WIN_SIDE];
      act[e]  = ((swmf_pkg::RAD_W+1)'(e / swmf_pkg::WIN_SIDE) <= span) &&
                ((swmf_pkg::RAD_W+1)'(e % swmf_pkg::WIN_SIDE) <= span);
    end
    for (int e = 0; e < swmf_pkg::WIN_N; e++) begin
      for (int f = 0; f < swmf_pkg::WIN_N; f++) begin
        lt[e][f] = (f != e) && ((vals[f] < vals[e]) || ((vals[f] == vals[e]) && (f < e)));
      end
    end
    // (2r+1)^2 / 2
    tgt = swmf_pkg::RANK_W'((({3'd0, span} + 5'd1) * ({3'd0, span} + 5'd1)) >> 1);
  end

  always_ff @(posedge clk) begin
    for (int e = 0; e < swmf_pkg::WIN_N; e++) begin
      lt_r[e]   <= lt[e];
      vals_r[e] <= vals[e];
    end
    act_r <= act;
    tgt_r <= tgt;
  end

  always_comb begin
    for (int e = 0; e < swmf_pkg::WIN_N; e++) begin
      hit[e] = act_r[e] &&
               (swmf_pkg::RANK_W'($countones(lt_r[e] & act_r)) == tgt_r);
    end
  end

  always_ff @(posedge clk) begin
    sel_r <= hit;
    for (int e = 0; e < swmf_pkg::WIN_N; e++) begin
      vals2_r[e] <= vals_r[e];
    end
  end

  always_comb begin
    median = '0;
    for (int e = 0; e < swmf_pkg::WIN_N; e++) begin
      median = median | (vals2_r[e] & {swmf_pkg::PIXEL_BITS{sel_r[e]}});
    end
  end

endmodule

// ===== hw/rtl/square_window_median_filter_unit.sv =====
// Channel   Direction  Word
// in_       input      cmd (pixel / flush), pixel_in
// out_      output     pixel_out, out_row, out_col, frame_end
// APB       config     image_size at 0x0, window_radius at 0x4
//
// One input word per clock while in_ready is high; a result it releases passes
// through the line store read, column shift, compare, rank and FIFO registers.
// Stalls come from the 8-entry output FIFO: in_ready drops only once eight
// results are in flight or waiting, so out_ready stalls are absorbed there.
// Reset (synchronous, rst_n low) clears counters and handshakes; line store
// contents are not cleared. Any register write restarts the frame counters.
module square_window_median_filter_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_cmd,
  input  logic [15:0]                 in_pixel_in,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [15:0]                 out_pixel_out,
  output logic [9:0]                  out_out_row,
  output logic [9:0]                  out_out_col,
  output logic                        out_frame_end,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int CW = swmf_pkg::COL_W;
  localparam int SW = swmf_pkg::SIZE_W;
  localparam int LW = swmf_pkg::LAG_W;

  // ---------------- configuration registers ----------------
  logic [SW-1:0]                 image_size_r;
  logic [swmf_pkg::RAD_W-1:0]    window_radius_r;
  logic                          cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_size_r    <= SW'(512);
      window_radius_r <= swmf_pkg::RAD_W'(1);
    end else if (cfg_we) begin
      unique case (paddr[2])
        swmf_pkg::REG_IMAGE_SIZE:    image_size_r    <= pwdata[SW-1:0];
        swmf_pkg::REG_WINDOW_RADIUS: window_radius_r <= pwdata[swmf_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      swmf_pkg::REG_IMAGE_SIZE:    prdata = {{(32-SW){1'b0}}, image_size_r};
      swmf_pkg::REG_WINDOW_RADIUS: prdata = {{(32-swmf_pkg::RAD_W){1'b0}}, window_radius_r};
      default:                     prdata = '0;
    endcase
  end

  // Effective size: 0 acts as 1, anything above the store width is clamped.
  logic [SW-1:0] n_eff;
  logic [SW-1:0] r_ext;
  logic [LW-1:0] lag;

  always_comb begin
    if (image_size_r == '0) begin
      n_eff = SW'(1);
    end else if (image_size_r > SW'(swmf_pkg::MAX_SIZE)) begin
      n_eff = SW'(swmf_pkg::MAX_SIZE);
    end else begin
      n_eff = image_size_r;
    end
    r_ext = SW'(window_radius_r);
    lag   = LW'(window_radius_r) * LW'(n_eff) + LW'(window_radius_r);
  end

  // ---------------- frame counters ----------------
  logic [CW-1:0]              in_row_r, in_row_nxt, in_col_r, in_col_nxt;
  logic [CW-1:0]              out_row_r, out_row_nxt, out_col_r, out_col_nxt;
  logic [swmf_pkg::SLOT_W-1:0] in_slot_r, in_slot_nxt, out_slot_r, out_slot_nxt;
  logic [LW-1:0]              waiting_r, waiting_nxt, waiting_inc;
  logic [SW-1:0]              in_col_inc, in_row_inc, out_col_inc, out_row_inc;
  logic                       acc, is_pix, emit;
  logic                       border_now, fe_now;

  assign acc    = in_valid & in_ready;
  assign is_pix = (in_cmd == swmf_pkg::CMD_PIXEL);

  always_comb begin
    in_row_nxt   = in_row_r;
    in_col_nxt   = in_col_r;
    in_slot_nxt  = in_slot_r;
    out_row_nxt  = out_row_r;
    out_col_nxt  = out_col_r;
    out_slot_nxt = out_slot_r;
    in_col_inc   = SW'(in_col_r) + SW'(1);
    in_row_inc   = SW'(in_row_r) + SW'(1);
    out_col_inc  = SW'(out_col_r) + SW'(1);
    out_row_inc  = SW'(out_row_r) + SW'(1);
    waiting_inc  = waiting_r + LW'(is_pix);

    if (is_pix) begin
      emit = waiting_inc > lag;
    end else begin
      emit = (in_row_r == '0) && (in_col_r == '0) && (waiting_r != '0);
    end

    if (acc && is_pix) begin
      if (in_col_inc >= n_eff) begin
        in_col_nxt  = '0;
        in_slot_nxt = in_slot_r + 1'b1;
        in_row_nxt  = (in_row_inc >= n_eff) ? '0 : in_row_inc[CW-1:0];
      end else begin
        in_col_nxt  = in_col_inc[CW-1:0];
      end
    end

    if (acc && emit) begin
      if (out_col_inc >= n_eff) begin
        out_col_nxt  = '0;
        out_slot_nxt = out_slot_r + 1'b1;
        out_row_nxt  = (out_row_inc >= n_eff) ? '0 : out_row_inc[CW-1:0];
      end else begin
        out_col_nxt  = out_col_inc[CW-1:0];
      end
    end

    waiting_nxt = acc ? (waiting_inc - LW'(emit)) : waiting_r;

    // Border: fewer than r rows or columns from an edge.
    border_now = (SW'(out_row_r) < r_ext) || (SW'(out_col_r) < r_ext) ||
                 (SW'(out_row_r) + r_ext >= n_eff) || (SW'(out_col_r) + r_ext >= n_eff);
    fe_now     = (SW'(out_row_r) == n_eff - SW'(1)) && (SW'(out_col_r) == n_eff - SW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      in_row_r   <= '0;
      in_col_r   <= '0;
      in_slot_r  <= '0;
      out_row_r  <= '0;
      out_col_r  <= '0;
      out_slot_r <= '0;
      waiting_r  <= '0;
    end else begin
      in_row_r   <= in_row_nxt;
      in_col_r   <= in_col_nxt;
      in_slot_r  <= in_slot_nxt;
      out_row_r  <= out_row_nxt;
      out_col_r  <= out_col_nxt;
      out_slot_r <= out_slot_nxt;
      waiting_r  <= waiting_nxt;
    end
  end

  // ---------------- line store: one bank per row slot ----------------
  // Port A reads the column being written (the rows above it), port B the
  // pixel at the output position for the border pass-through.
  swmf_pkg::pixel_t rd_a [swmf_pkg::SLOTS];
  swmf_pkg::pixel_t rd_b [swmf_pkg::SLOTS];

  for (genvar b = 0; b < swmf_pkg::SLOTS; b++) begin : g_bank
    swmf_ram #(
      .WIDTH (swmf_pkg::PIXEL_BITS),
      .DEPTH (swmf_pkg::MAX_SIZE)
    ) u_ram (
      .clk     (clk),
      .we      (acc && is_pix && (in_slot_r == swmf_pkg::SLOT_W'(b))),
      .waddr   (in_col_r),
      .wdata   (in_pixel_in),
      .raddr_a (in_col_r),
      .rdata_a (rd_a[b]),
      .raddr_b (out_col_r),
      .rdata_b (rd_b[b])
    );
  end

  // ---------------- pipeline ----------------
  logic                         s1_emit_r, s1_pix_r, s2_emit_r, s3_emit_r, s4_emit_r;
  swmf_pkg::pixel_t             s1_pixel_r;
  logic [swmf_pkg::SLOT_W-1:0]  s1_slot_r, s1_oslot_r;
  swmf_pkg::meta_t              s1_meta_r, s2_meta_r, s3_meta_r, s4_meta_r;
  swmf_pkg::pixel_t             s2_bval_r, s3_bval_r, s4_bval_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_emit_r <= 1'b0;
      s1_pix_r  <= 1'b0;
      s2_emit_r <= 1'b0;
      s3_emit_r <= 1'b0;
      s4_emit_r <= 1'b0;
    end else begin
      s1_emit_r <= acc & emit;
      s1_pix_r  <= acc & is_pix;
      s2_emit_r <= s1_emit_r;
      s3_emit_r <= s2_emit_r;
      s4_emit_r <= s3_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_pixel_r <= in_pixel_in;
    s1_slot_r  <= in_slot_r;
    s1_oslot_r <= out_slot_r;
    s1_meta_r  <= '{border: border_now, row: out_row_r, col: out_col_r, frame_end: fe_now};
    s2_meta_r  <= s1_meta_r;
    s2_bval_r  <= rd_b[s1_oslot_r];
    s3_meta_r  <= s2_meta_r;
    s3_bval_r  <= s2_bval_r;
    s4_meta_r  <= s3_meta_r;
    s4_bval_r  <= s3_bval_r;
  end

  // New column: the incoming pixel on top, the rows above it beneath.
  swmf_pkg::column_t new_col;
  swmf_pkg::window_t win;

  always_comb begin
    new_col[0] = s1_pixel_r;
    for (int t = 1; t < swmf_pkg::WIN_SIDE; t++) begin
      new_col[t] = rd_a[s1_slot_r - swmf_pkg::SLOT_W'(t)];
    end
  end

  // Chain of column cells: cell 0 holds the newest column.
  for (genvar c = 0; c < swmf_pkg::WIN_SIDE; c++) begin : g_cell
    swmf_cell u_cell (
      .clk     (clk),
      .shift   (s1_pix_r),
      .col_in  ((c == 0) ? new_col : win[(c == 0) ? 0 : c - 1]),
      .col_out (win[c])
    );
  end

  swmf_pkg::pixel_t median;

  swmf_rank u_rank (
    .clk    (clk),
    .win    (win),
    .radius (window_radius_r),
    .median (median)
  );

  // ---------------- output FIFO with credit count ----------------
  swmf_pkg::out_word_t              fifo_r [swmf_pkg::FIFO_DEPTH];
  logic [swmf_pkg::FIFO_AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [swmf_pkg::FIFO_AW:0]       fill_r, used_r;
  logic                             pop;

  assign pop       = out_valid & out_ready;
  assign out_valid = (fill_r != '0);
  assign in_ready  = (used_r < (swmf_pkg::FIFO_AW+1)'(swmf_pkg::FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (s4_emit_r) begin
      fifo_r[wr_ptr_r] <= '{pixel:     s4_meta_r.border ? s4_bval_r : median,
                            row:       s4_meta_r.row,
                            col:       s4_meta_r.col,
                            frame_end: s4_meta_r.frame_end};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
      used_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + swmf_pkg::FIFO_AW'(s4_emit_r);
      rd_ptr_r <= rd_ptr_r + swmf_pkg::FIFO_AW'(pop);
      fill_r   <= fill_r + (swmf_pkg::FIFO_AW+1)'(s4_emit_r) - (swmf_pkg::FIFO_AW+1)'(pop);
      used_r   <= used_r + (swmf_pkg::FIFO_AW+1)'(acc & emit) - (swmf_pkg::FIFO_AW+1)'(pop);
    end
  end

  assign out_pixel_out = fifo_r[rd_ptr_r].pixel;
  assign out_out_row   = fifo_r[rd_ptr_r].row;
  assign out_out_col   = fifo_r[rd_ptr_r].col;
  assign out_frame_end = fifo_r[rd_ptr_r].frame_end;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

  // ---------------------------------------------------------------------
  // Median predictor and store of expected result words
  // ---------------------------------------------------------------------
  typedef struct {
    logic [15:0] pixel;
    logic [9:0]  row;
    logic [9:0]  col;
    logic        frame_end;
  } result_word_t;

  class median_scoreboard;
    logic [15:0]  rows_mem [0:swmf_pkg::SLOTS*swmf_pkg::MAX_SIZE-1];
    logic [15:0]  win [0:swmf_pkg::WIN_N-1];
    logic [10:0]  size_reg;
    logic [1:0]   radius_reg;
    int unsigned  in_row, in_col, out_row, out_col, in_slot, out_slot, waiting;
    result_word_t pending [$];
    int           mismatches;

    function void clear_counts();
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
      in_slot = 0; out_slot = 0; waiting = 0;
    endfunction

    function void reset_state();
      size_reg = 11'd512;
      radius_reg = 2'd1;
      mismatches = 0;
      clear_counts();
    endfunction

    function int unsigned side();
      if (size_reg == 0) return 1;
      if (size_reg > swmf_pkg::MAX_SIZE) return swmf_pkg::MAX_SIZE;
      return size_reg;
    endfunction

    function int unsigned rad();
      return (radius_reg > swmf_pkg::MAX_RADIUS) ? swmf_pkg::MAX_RADIUS : radius_reg;
    endfunction

    function bit at_frame_start();
      return in_row == 0 && in_col == 0;
    endfunction

    function void write_reg(logic idx, logic [31:0] val);
      if (idx == swmf_pkg::REG_IMAGE_SIZE) size_reg = val[10:0];
      else radius_reg = val[1:0];
      clear_counts();
    endfunction

    function logic [15:0] rd(int unsigned slot, int unsigned col);
      return rows_mem[(slot % swmf_pkg::SLOTS) * swmf_pkg::MAX_SIZE +
                      (col % swmf_pkg::MAX_SIZE)];
    endfunction

    // median of the window around the next output position, or the pixel on the border
    function logic [15:0] window_median(int unsigned n, int unsigned r);
      int unsigned k, a, b, p, slot;
      logic [15:0] v;
      k = 0;
      if (out_row < r || out_col < r || out_row + r >= n || out_col + r >= n)
        return rd(out_slot, out_col);
      for (a = 0; a <= 2 * r; a++) begin
        slot = (out_slot + swmf_pkg::SLOTS - r + a) % swmf_pkg::SLOTS;
        for (b = 0; b <= 2 * r; b++) begin
          v = rd(slot, out_col - r + b);
          p = k;
          while (p > 0 && win[p-1] > v) begin
            win[p] = win[p-1];
            p--;
          end
          win[p] = v;
          k++;
        end
      end
      return win[k/2];
    endfunction

    function void note_input(logic cmd, logic [15:0] pix);
      int unsigned n, r;
      bit release_one;
      result_word_t w;
      n = side();
      r = rad();
      if (cmd == swmf_pkg::CMD_PIXEL) begin
        rows_mem[(in_slot % swmf_pkg::SLOTS) * swmf_pkg::MAX_SIZE +
                 (in_col % swmf_pkg::MAX_SIZE)] = pix;
        in_col++;
        if (in_col >= n) begin
          in_col = 0;
          in_slot = (in_slot + 1) % swmf_pkg::SLOTS;
          in_row++;
          if (in_row >= n) in_row = 0;
        end
        waiting++;
        release_one = waiting > r * n + r;
      end else begin
        release_one = at_frame_start() && waiting > 0;
      end
      if (!release_one) return;
      w.pixel = window_median(n, r);
      w.row = out_row[9:0];
      w.col = out_col[9:0];
      w.frame_end = (out_row == n - 1 && out_col == n - 1);
      pending.push_back(w);
      waiting--;
      out_col++;
      if (out_col >= n) begin
        out_col = 0;
        out_slot = (out_slot + 1) % swmf_pkg::SLOTS;
        out_row++;
        if (out_row >= n) out_row = 0;
      end
    endfunction

    function void check_result(logic [15:0] pix, logic [9:0] row, logic [9:0] col, logic fe);
      result_word_t w;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: pixel %h row %0d col %0d fe %b", pix, row, col, fe);
        return;
      end
      w = pending.pop_front();
      if (w.pixel !== pix || w.row !== row || w.col !== col || w.frame_end !== fe) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp pixel %h row %0d col %0d fe %b, got %h %0d %0d %b",
                   w.pixel, w.row, w.col, w.frame_end, pix, row, col, fe);
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------
  // Block and its connections
  // ---------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid, in_ready, in_cmd;
  logic [15:0] in_pixel_in;
  logic        out_valid, out_ready, out_frame_end;
  logic [15:0] out_pixel_out;
  logic [9:0]  out_out_row, out_out_col;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  median_scoreboard sb;
  int unsigned burst_left;
  int unsigned words_sent;
  int unsigned results_seen;
  int unsigned idle_cycles;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 20;   // pipeline depth plus margin
  localparam int LONG_HOLD      = 400;  // receiver hold-off, fills the FIFO

  square_window_median_filter_unit DUT (.*);

  always #10 clk = ~clk;

  initial begin
    sb = new();
    sb.reset_state();
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_cmd      <= swmf_pkg::CMD_PIXEL;
    in_pixel_in <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
  end

  // Watchdog: cycles with no word moving on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Receiver: checks every accepted word, stalls on its own pattern, and
  // holds off once for a long stretch so the input side backs up
  initial begin : receiver
    int unsigned mode, mode_left, hold_left;
    bit          held;
    mode = 0; mode_left = 0; hold_left = 0; held = 0;
    results_seen = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        sb.check_result(out_pixel_out, out_out_row, out_out_col, out_frame_end);
        results_seen++;
      end
      if (!held && results_seen >= 150) begin
        held = 1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(8, 80);
        end
        mode_left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(0, 1);
          default: out_ready <= ($urandom_range(0, 5) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // Driving tasks
  // ---------------------------------------------------------------------
  task automatic send_word(logic cmd, logic [15:0] pix);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    in_cmd      <= cmd;
    in_pixel_in <= pix;
    do @(posedge clk); while (!in_ready);
    sb.note_input(cmd, pix);
    words_sent++;
  endtask

  // let every expected word out and the pipeline settle before a register write
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(logic idx, logic [31:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.write_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 3));      // lots of ties in the window
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // one setting: registers, pixels with some noise flushes, then drain
  task automatic run_phase(int unsigned sz, int unsigned rd, int unsigned npix);
    int unsigned i;
    settle();
    apb_write(swmf_pkg::REG_IMAGE_SIZE, sz);
    apb_write(swmf_pkg::REG_WINDOW_RADIUS, rd);
    for (i = 0; i < npix; i++) begin
      if ($urandom_range(0, 15) == 0)
        send_word(swmf_pkg::CMD_FLUSH, 16'($urandom_range(0, 65535)));
      send_word(swmf_pkg::CMD_PIXEL, rand_pixel());
    end
    // flushes only release words once the frame is complete
    while (sb.waiting > 0 && sb.at_frame_start())
      send_word(swmf_pkg::CMD_FLUSH, 16'($urandom_range(0, 65535)));
    send_word(swmf_pkg::CMD_FLUSH, 16'hFFFF);
  endtask

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin : stimulus
    int unsigned i, n, frames;
    burst_left = 0;
    words_sent = 0;
    idle_cycles = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: 5x5 frame, 3x3 window, extreme pixels, flush mid-frame does nothing
    apb_write(swmf_pkg::REG_IMAGE_SIZE, 5);
    apb_write(swmf_pkg::REG_WINDOW_RADIUS, 1);
    for (i = 0; i < 25; i++) begin
      if (i == 12) send_word(swmf_pkg::CMD_FLUSH, 16'hA5A5);
      send_word(swmf_pkg::CMD_PIXEL,
                (i % 3 == 0) ? 16'hFFFF : ((i % 3 == 1) ? 16'h0000 : 16'h8001));
    end
    while (sb.waiting > 0) send_word(swmf_pkg::CMD_FLUSH, 16'h0000);

    // extremes: size 0 acts as 1, oversize only partly filled, radius 0, small frame
    run_phase(0, 3, 4);
    run_phase(2047, 2, 40);
    run_phase(3, 0, 18);
    run_phase(2, 3, 8);
    run_phase(7, 3, 49);
    run_phase(1024, 0, 30);

    while (words_sent < 1700) begin
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 24) : $urandom_range(1, 14);
      frames = (n > 14) ? 1 : $urandom_range(1, 3);
      if ($urandom_range(0, 5) == 0)
        run_phase(n, $urandom_range(0, 3), $urandom_range(1, n * n));   // broken frame
      else
        run_phase(n, $urandom_range(0, 3), frames * n * n);
    end

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== square_window_median_filter_unit.f =====
hw/rtl/swmf_pkg.sv
hw/rtl/swmf_ram.sv
hw/rtl/swmf_cell.sv
hw/rtl/swmf_rank.sv
hw/rtl/square_window_median_filter_unit.sv
verif/tb.sv
